@@ hw/rtl/dqr_pkg.sv @@
package dqr_pkg;

    // Default ring depth and fixed field widths
    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int CAP_W     = 5;
    localparam int CAP_RESET = 16;

    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_REAR  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                    mode;
        logic signed [DATA_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic                     accepted;
        logic signed [DATA_W-1:0] popped_value;
        logic                     is_empty;
        logic                     is_full;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
    } t_result;

    // Outcome of one operation, from the index control to the result stage
    typedef struct packed {
        logic accepted;
        logic is_empty;
        logic is_full;
    } t_status;

endpackage

@@ hw/rtl/dqr_ram.sv @@
module dqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one port, read two ports, registered read (old data on collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ hw/rtl/dqr_ctrl.sv @@
module dqr_ctrl #(
    parameter int DEPTH = dqr_pkg::DEPTH_DEF,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  dqr_pkg::t_mode          i_mode,
    input  logic                    i_cfg_we,
    input  logic [dqr_pkg::CAP_W-1:0] i_cfg_data,
    output logic [IW-1:0]           o_head,
    output logic [IW-1:0]           o_tail,
    output logic [IW-1:0]           o_n_head,
    output logic [IW-1:0]           o_n_tail,
    output logic                    o_wr_en,
    output logic [IW-1:0]           o_wr_addr,
    output dqr_pkg::t_status        o_status
);

    localparam int CW       = (IW + 1 > dqr_pkg::CAP_W) ? IW + 1 : dqr_pkg::CAP_W;
    localparam int LAST_RST = (dqr_pkg::CAP_RESET > DEPTH) ? DEPTH - 1
                                                           : dqr_pkg::CAP_RESET - 1;

    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic          r_empty, n_empty;
    logic [IW-1:0] r_last;
    logic [CW-1:0] cap_ext;
    logic [IW-1:0] cfg_last;
    logic          full;

    function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i,
                                               input logic [IW-1:0] last);
        return (i >= last) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i,
                                               input logic [IW-1:0] last);
        return (i == '0) ? last : i - 1'b1;
    endfunction

    // Clamp the written capacity into 1..DEPTH, keep it as the last index
    always_comb begin
        cap_ext = CW'(i_cfg_data);
        if (cap_ext == '0) begin
            cfg_last = '0;
        end else if (cap_ext > CW'(DEPTH)) begin
            cfg_last = IW'(DEPTH - 1);
        end else begin
            cfg_last = IW'(cap_ext - 1'b1);
        end
    end

    assign full = !r_empty && (idx_next(r_tail, r_last) == r_head);

    // Advance head, tail and empty flag for the operation
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_empty   = r_empty;
        o_wr_en   = 1'b0;
        o_wr_addr = r_head;
        o_status.accepted = 1'b0;
        if (i_accept) begin
            unique case (i_mode) inside
                dqr_pkg::MODE_PUSH_FRONT, dqr_pkg::MODE_PUSH_REAR: begin
                    if (!full) begin
                        o_status.accepted = 1'b1;
                        o_wr_en = 1'b1;
                        if (r_empty) begin
                            n_head    = '0;
                            n_tail    = '0;
                            n_empty   = 1'b0;
                            o_wr_addr = '0;
                        end else if (i_mode == dqr_pkg::MODE_PUSH_FRONT) begin
                            n_head    = idx_prev(r_head, r_last);
                            o_wr_addr = n_head;
                        end else begin
                            n_tail    = idx_next(r_tail, r_last);
                            o_wr_addr = n_tail;
                        end
                    end
                end
                dqr_pkg::MODE_POP_FRONT: begin
                    if (!r_empty) begin
                        o_status.accepted = 1'b1;
                        if (r_head == r_tail) begin
                            n_empty = 1'b1;
                        end else begin
                            n_head = idx_next(r_head, r_last);
                        end
                    end
                end
                dqr_pkg::MODE_POP_REAR: begin
                    if (!r_empty) begin
                        o_status.accepted = 1'b1;
                        if (r_head == r_tail) begin
                            n_empty = 1'b1;
                        end else begin
                            n_tail = idx_prev(r_tail, r_last);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        o_status.is_empty = n_empty;
        o_status.is_full  = !n_empty && (idx_next(n_tail, r_last) == n_head);
    end

    // Hold index state and capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
            r_last  <= IW'(LAST_RST);
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
            if (i_cfg_we) begin
                r_last <= cfg_last;
            end
        end
    end

    assign o_head   = r_head;
    assign o_tail   = r_tail;
    assign o_n_head = n_head;
    assign o_n_tail = n_tail;

`ifndef SYNTH
    a_first_push_slot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_empty && !i_mode[1]) |=> (r_head == '0 && r_tail == '0 && !r_empty))
        else $error("first push did not land in slot 0");

    a_last_pop_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_mode[1] && !r_empty && r_head == r_tail) |=> r_empty)
        else $error("pop of the only entry did not empty the deque");

    a_full_refuses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && full && !i_mode[1]) |=> ($stable(r_head) && $stable(r_tail)))
        else $error("push into a full deque moved an index");
`endif

endmodule

@@ hw/rtl/double_ended_queue_ring.sv @@
// Ring-buffer deque of signed 32-bit words, up to DEPTH entries.
// Command channel: present an item on i_item and raise start; the item is
// transferred at a rising edge where start is high and busy is low. Each
// item pushes at the front or rear, or pops from the front or rear.
// Result channel: one result per item, on o_result for exactly one cycle
// while o_strobe is high, in the cycle right after the transfer. The
// receiver cannot hold results off, and none is needed: busy stays low in
// normal operation, so one item is taken every cycle.
// Front and rear words come straight from the two read ports of the entry
// RAM, with a bypass for the word written at the previous edge.
// Configuration: i_cfg_data carries the capacity, written when i_cfg_valid
// and o_cfg_ready are high; write it only while no result is pending.
// Reset (synchronous, active low): deque empty, indices zero, capacity 16
// (clamped to DEPTH), busy high during reset. Entry contents are not reset.
module double_ended_queue_ring #(
    parameter int DEPTH = dqr_pkg::DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  dqr_pkg::t_item            i_item,
    output logic                      o_strobe,
    output dqr_pkg::t_result          o_result,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [dqr_pkg::CAP_W-1:0] i_cfg_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                      accept;
    logic                      r_busy;
    logic [IW-1:0]             head, tail, n_head, n_tail;
    logic                      wr_en;
    logic [IW-1:0]             wr_addr;
    dqr_pkg::t_status          status;
    logic [dqr_pkg::DATA_W-1:0] rdata_a, rdata_b;
    logic [dqr_pkg::DATA_W-1:0] cur_front, cur_rear;
    logic [dqr_pkg::DATA_W-1:0] popped;

    logic                      r_fwd_en;
    logic [IW-1:0]             r_fwd_addr;
    logic [dqr_pkg::DATA_W-1:0] r_fwd_data;

    logic                      r_strobe;
    logic                      r_accepted;
    logic [dqr_pkg::DATA_W-1:0] r_popped;
    logic                      r_is_empty;
    logic                      r_is_full;

    assign accept      = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;

    dqr_ctrl #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_mode     (i_item.mode),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_head     (head),
        .o_tail     (tail),
        .o_n_head   (n_head),
        .o_n_tail   (n_tail),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_status   (status)
    );

    dqr_ram #(
        .WIDTH (dqr_pkg::DATA_W),
        .DEPTH (DEPTH),
        .AW    (IW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (wr_addr),
        .i_wdata   (i_item.value),
        .i_raddr_a (n_head),
        .i_raddr_b (n_tail),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // Bypass the word written at the last edge, the RAM read returns old data
    assign cur_front = (r_fwd_en && r_fwd_addr == head) ? r_fwd_data : rdata_a;
    assign cur_rear  = (r_fwd_en && r_fwd_addr == tail) ? r_fwd_data : rdata_b;

    // Pick the removed word from the words before this step
    always_comb begin
        popped = dqr_pkg::ALL_ONES;
        if (status.accepted) begin
            case (i_item.mode)
                dqr_pkg::MODE_POP_FRONT: popped = cur_front;
                dqr_pkg::MODE_POP_REAR:  popped = cur_rear;
                default:                 popped = dqr_pkg::ALL_ONES;
            endcase
        end
    end

    // Control registers: busy, result strobe, bypass valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_strobe <= 1'b0;
            r_fwd_en <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_strobe <= accept;
            r_fwd_en <= wr_en;
        end
    end

    // Result and bypass payload
    always_ff @(posedge i_clk) begin
        r_fwd_addr <= wr_addr;
        r_fwd_data <= i_item.value;
        if (accept) begin
            r_accepted <= status.accepted;
            r_popped   <= popped;
            r_is_empty <= status.is_empty;
            r_is_full  <= status.is_full;
        end
    end

    assign o_strobe              = r_strobe;
    assign o_result.accepted     = r_accepted;
    assign o_result.popped_value = r_popped;
    assign o_result.is_empty     = r_is_empty;
    assign o_result.is_full      = r_is_full;
    assign o_result.front_value  = r_is_empty ? dqr_pkg::ALL_ONES : cur_front;
    assign o_result.rear_value   = r_is_empty ? dqr_pkg::ALL_ONES : cur_rear;

`ifndef SYNTH
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_strobe)
        else $error("transfer without a result in the next cycle");

    a_not_empty_and_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_result.is_empty && o_result.is_full))
        else $error("result reports empty and full together");

    a_refused_pops_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.accepted) |-> (o_result.popped_value == dqr_pkg::ALL_ONES))
        else $error("refused operation returned a popped word");
`endif

endmodule

@@ verif/tb_double_ended_queue_ring.sv @@
// Deque predictor and expected-result store
class deque_scoreboard;
    logic [dqr_pkg::DATA_W-1:0] ring [dqr_pkg::DEPTH_DEF];
    int unsigned       head_idx;
    int unsigned       tail_idx;
    bit                empty_now;
    int unsigned       cap_setting;
    dqr_pkg::t_result  expected_q[$];
    int                errors;
    int                n_checked;
    int                n_refused_push;
    int                n_refused_pop;

    function new();
        foreach (ring[i]) ring[i] = '0;
        head_idx       = 0;
        tail_idx       = 0;
        empty_now      = 1'b1;
        cap_setting    = dqr_pkg::CAP_RESET;
        errors         = 0;
        n_checked      = 0;
        n_refused_push = 0;
        n_refused_pop  = 0;
    endfunction

    // Clamp the register to the usable ring size
    function int unsigned ring_size();
        if (cap_setting == 0) return 1;
        if (cap_setting > dqr_pkg::DEPTH_DEF) return dqr_pkg::DEPTH_DEF;
        return cap_setting;
    endfunction

    function int unsigned step_up(int unsigned i);
        return (i + 1 >= ring_size()) ? 0 : i + 1;
    endfunction

    function int unsigned step_down(int unsigned i);
        return (i == 0) ? ring_size() - 1 : i - 1;
    endfunction

    function bit full_now();
        return !empty_now && step_up(tail_idx) == head_idx;
    endfunction

    function void set_capacity(logic [dqr_pkg::CAP_W-1:0] v);
        cap_setting = v;
    endfunction

    // Apply one transferred operation and queue the result it must produce
    function void note_item(dqr_pkg::t_item it);
        dqr_pkg::t_result r;
        r.accepted     = 1'b0;
        r.popped_value = dqr_pkg::ALL_ONES;
        case (it.mode)
            dqr_pkg::MODE_PUSH_FRONT, dqr_pkg::MODE_PUSH_REAR: begin
                if (full_now()) begin
                    n_refused_push++;
                end else begin
                    // A push into an empty deque always lands in slot 0
                    if (empty_now) begin
                        head_idx  = 0;
                        tail_idx  = 0;
                        empty_now = 1'b0;
                        ring[0]   = it.value;
                    end else if (it.mode == dqr_pkg::MODE_PUSH_FRONT) begin
                        head_idx = step_down(head_idx);
                        ring[head_idx % dqr_pkg::DEPTH_DEF] = it.value;
                    end else begin
                        tail_idx = step_up(tail_idx);
                        ring[tail_idx % dqr_pkg::DEPTH_DEF] = it.value;
                    end
                    r.accepted = 1'b1;
                end
            end
            default: begin
                if (empty_now) begin
                    n_refused_pop++;
                end else begin
                    // Removing the last entry keeps the indices
                    if (it.mode == dqr_pkg::MODE_POP_FRONT) begin
                        r.popped_value = ring[head_idx % dqr_pkg::DEPTH_DEF];
                        if (head_idx == tail_idx) empty_now = 1'b1;
                        else head_idx = step_up(head_idx);
                    end else begin
                        r.popped_value = ring[tail_idx % dqr_pkg::DEPTH_DEF];
                        if (head_idx == tail_idx) empty_now = 1'b1;
                        else tail_idx = step_down(tail_idx);
                    end
                    r.accepted = 1'b1;
                end
            end
        endcase
        r.is_empty    = empty_now;
        r.is_full     = full_now();
        r.front_value = empty_now ? dqr_pkg::ALL_ONES : ring[head_idx % dqr_pkg::DEPTH_DEF];
        r.rear_value  = empty_now ? dqr_pkg::ALL_ONES : ring[tail_idx % dqr_pkg::DEPTH_DEF];
        expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [dqr_pkg::DATA_W-1:0] want,
                                logic [dqr_pkg::DATA_W-1:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, name, want, got);
        end
    endfunction

    // Compare one result against the oldest expectation
    function void check_result(dqr_pkg::t_result got);
        dqr_pkg::t_result want;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 40)
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
            return;
        end
        want = expected_q.pop_front();
        n_checked++;
        compare_field("accepted", want.accepted, got.accepted);
        compare_field("popped_value", want.popped_value, got.popped_value);
        compare_field("is_empty", want.is_empty, got.is_empty);
        compare_field("is_full", want.is_full, got.is_full);
        compare_field("front_value", want.front_value, got.front_value);
        compare_field("rear_value", want.rear_value, got.rear_value);
    endfunction
endclass

module tb_double_ended_queue_ring;

    localparam int CLK_PERIOD = 20;
    localparam int RUN_LIMIT  = CLK_PERIOD * 200000;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      start       = 1'b0;
    logic                      busy;
    dqr_pkg::t_item            i_item      = '0;
    logic                      o_strobe;
    dqr_pkg::t_result          o_result;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [dqr_pkg::CAP_W-1:0] i_cfg_data  = '0;

    bit               steady      = 1'b0;
    int               n_sent      = 0;
    int               n_cfg       = 0;
    deque_scoreboard  sb          = new();

    double_ended_queue_ring uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // Check every strobed result
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) sb.check_result(o_result);
    end

    // Extremes now and then, random words otherwise
    function automatic logic [dqr_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return dqr_pkg::ALL_ONES;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    // Present one operation, with an optional gap first, and hold it until transfer
    task automatic send_op(dqr_pkg::t_mode m, logic [dqr_pkg::DATA_W-1:0] v);
        if (!steady && $urandom_range(0, 99) < 33) begin
            @(negedge i_clk) start = 1'b0;
            repeat ($urandom_range(0, 1)) @(negedge i_clk);
        end
        @(negedge i_clk);
        start        = 1'b1;
        i_item.mode  = m;
        i_item.value = v;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_item(i_item);
        n_sent++;
    endtask

    // Drop start and hold until every expected result is in
    task automatic wait_drained();
        @(negedge i_clk) start = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cap(logic [dqr_pkg::CAP_W-1:0] v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_capacity(v);
        n_cfg++;
        @(negedge i_clk) i_cfg_valid = 1'b0;
    endtask

    // Streaks of push-heavy and pop-heavy traffic so the deque swings full and empty
    task automatic run_phase(int n_items, bit pause_mid);
        int             left_in_streak;
        bit             push_heavy;
        bit             is_push;
        dqr_pkg::t_mode m;
        left_in_streak = 0;
        push_heavy     = 1'b1;
        for (int k = 0; k < n_items; k++) begin
            if (left_in_streak == 0) begin
                push_heavy     = 1'($urandom_range(0, 1));
                left_in_streak = $urandom_range(4, 40);
            end
            left_in_streak--;
            is_push = push_heavy ? ($urandom_range(0, 99) < 75)
                                 : ($urandom_range(0, 99) < 25);
            if (is_push) begin
                m = $urandom_range(0, 1) ? dqr_pkg::MODE_PUSH_REAR
                                         : dqr_pkg::MODE_PUSH_FRONT;
            end else begin
                m = $urandom_range(0, 1) ? dqr_pkg::MODE_POP_REAR
                                         : dqr_pkg::MODE_POP_FRONT;
            end
            if (pause_mid && k == n_items / 2) wait_drained();
            send_op(m, is_push ? pick_word() : $urandom);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // Pops on the empty deque are refused
        send_op(dqr_pkg::MODE_POP_FRONT, '0);
        send_op(dqr_pkg::MODE_POP_REAR, dqr_pkg::ALL_ONES);
        // First push at the front still lands in slot 0, then head wraps below 0
        send_op(dqr_pkg::MODE_PUSH_FRONT, 32'h8000_0000);
        send_op(dqr_pkg::MODE_PUSH_REAR, 32'h7fff_ffff);
        send_op(dqr_pkg::MODE_PUSH_REAR, dqr_pkg::ALL_ONES);
        send_op(dqr_pkg::MODE_PUSH_FRONT, '0);
        // Fill to capacity so every ring slot holds a written word
        repeat (12) send_op(dqr_pkg::MODE_PUSH_REAR, $urandom);
        // Pushes on a full deque are refused
        send_op(dqr_pkg::MODE_PUSH_REAR, pick_word());
        send_op(dqr_pkg::MODE_PUSH_FRONT, pick_word());
        send_op(dqr_pkg::MODE_POP_FRONT, $urandom);
        send_op(dqr_pkg::MODE_POP_REAR, $urandom);

        // Capacity sweep, kept contents included; 0 acts as 1, 31 as full depth
        write_cap(5'd0);
        run_phase(100, 1'b0);
        write_cap(5'd31);
        steady = 1'b1;
        run_phase(200, 1'b0);
        steady = 1'b0;
        write_cap(5'd1);
        run_phase(100, 1'b0);
        write_cap(5'd2);
        run_phase(100, 1'b0);
        write_cap(5'd16);
        run_phase(200, 1'b1);
        write_cap(5'd9);
        run_phase(100, 1'b0);
        repeat (3) begin
            write_cap(dqr_pkg::CAP_W'($urandom_range(0, 31)));
            run_phase(100, 1'b0);
        end

        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("Sent %0d deque operations across %0d capacity writes; %0d results checked.",
                 n_sent, n_cfg, sb.n_checked);
        $display("Refused pushes when full: %0d, refused pops when empty: %0d, mismatches: %0d.",
                 sb.n_refused_push, sb.n_refused_pop, sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(RUN_LIMIT);
        $display("Timeout with %0d results outstanding", sb.expected_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
